// File: rtl/egbw_pkg.sv
// ----------------------------------------------------------------------------
// egbw_pkg
// Types and constants shared by the Exp-Golomb bit stream writer modules.
// ----------------------------------------------------------------------------
package egbw_pkg;

    localparam int WORD_BITS  = 32;
    localparam int CNT_BITS   = 5;
    localparam int CODE_BITS  = 63;
    localparam int NBITS_W    = 6;

    localparam logic [2:0] MODE_RAW   = 3'd0;
    localparam logic [2:0] MODE_UE    = 3'd1;
    localparam logic [2:0] MODE_SE    = 3'd2;
    localparam logic [2:0] MODE_ALIGN = 3'd3;
    localparam logic [2:0] MODE_TRAIL = 3'd4;
    localparam logic [2:0] MODE_FLUSH = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
        logic [5:0]  length;
        logic        fill_bit;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic [5:0]  valid_bits;
        logic        is_last;
        logic [31:0] total_bits;
    } out_item_t;

    // One classified operation: right-aligned bits to append, their count,
    // a flush request and the running bit total after the operation.
    typedef struct packed {
        logic [CODE_BITS-1:0] bits;
        logic [NBITS_W-1:0]   nbits;
        logic                 flush;
        logic [31:0]          total;
    } op_t;

endpackage

// File: rtl/egbw_stream_if.sv
// ----------------------------------------------------------------------------
// egbw_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface egbw_stream_if #(
    parameter type payload_t = logic [0:0]
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/egbw_front.sv
// ----------------------------------------------------------------------------
// egbw_front
// Accepts syntax elements, turns each into a bit string with its length and
// keeps the running bit total that byte alignment depends on.
// ----------------------------------------------------------------------------
module egbw_front
    import egbw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    egbw_stream_if.sink   in_stream,
    egbw_stream_if.source op_stream
);

    logic [31:0] total_reg;
    logic [31:0] total_next;

    in_item_t    item;
    op_t         op;
    logic        mode_ok;
    logic [5:0]  raw_n;
    logic [31:0] raw_mask;
    logic [31:0] se_mag;
    logic [31:0] code_v;
    logic [5:0]  code_len;
    logic [2:0]  align_left;
    logic [2:0]  trail_off;
    logic [2:0]  trail_left;

    assign item = in_stream.data;

    always_comb
    begin
        mode_ok = item.mode inside {[MODE_RAW:MODE_FLUSH]};

        raw_n    = (item.length > 6'd32) ? 6'd32 : item.length;
        raw_mask = (raw_n == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << raw_n[4:0]) - 32'd1);

        // Code number plus one, saturating at all ones.
        se_mag = 32'd0 - item.value;
        if (item.mode == MODE_SE)
        begin
            if (item.value[31])
            begin
                code_v = (se_mag == 32'h8000_0000) ? 32'hFFFF_FFFF : {se_mag[30:0], 1'b1};
            end
            else if (item.value == 32'd0)
            begin
                code_v = 32'd1;
            end
            else
            begin
                code_v = {item.value[30:0], 1'b0};
            end
        end
        else
        begin
            code_v = (item.value == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : item.value + 32'd1;
        end

        code_len = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (code_v[i])
            begin
                code_len = 6'(i + 1);
            end
        end

        align_left = 3'd0 - total_reg[2:0];
        trail_off  = total_reg[2:0] + 3'd1;
        trail_left = 3'd0 - trail_off;

        op.bits  = '0;
        op.nbits = '0;
        op.flush = 1'b0;
        case (item.mode)
            MODE_RAW:
            begin
                op.bits  = CODE_BITS'(item.value & raw_mask);
                op.nbits = raw_n;
            end
            MODE_UE, MODE_SE:
            begin
                // Leading zeros of the code are the zero bits above code_v.
                op.bits  = CODE_BITS'(code_v);
                op.nbits = NBITS_W'((7'(code_len) << 1) - 7'd1);
            end
            MODE_ALIGN:
            begin
                op.bits  = item.fill_bit ? CODE_BITS'((8'd1 << align_left) - 8'd1) : '0;
                op.nbits = NBITS_W'(align_left);
            end
            MODE_TRAIL:
            begin
                op.bits  = CODE_BITS'(8'd1 << trail_left);
                op.nbits = NBITS_W'(4'(trail_left) + 4'd1);
            end
            MODE_FLUSH:
            begin
                op.flush = 1'b1;
            end
            default:
            begin
                op.bits = '0;
            end
        endcase

        total_next = total_reg + 32'(op.nbits);
        op.total   = total_next;
    end

    assign op_stream.valid = in_stream.valid && mode_ok;
    assign op_stream.data  = op;
    assign in_stream.ready = op_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 32'd0;
        end
        else if (in_stream.valid && in_stream.ready && mode_ok)
        begin
            total_reg <= total_next;
        end
    end

endmodule

// File: rtl/egbw_queue.sv
// ----------------------------------------------------------------------------
// egbw_queue
// Short first-in first-out queue of classified operations between the front
// and the packer.
// ----------------------------------------------------------------------------
module egbw_queue
    import egbw_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    egbw_stream_if.sink   sink_ch,
    egbw_stream_if.source source_ch
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign sink_ch.ready   = (count_reg != CNT_W'(DEPTH));
    assign source_ch.valid = (count_reg != '0);
    assign source_ch.data  = mem_reg[rd_ptr_reg];

    assign push = sink_ch.valid && sink_ch.ready;
    assign pop  = source_ch.valid && source_ch.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= sink_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/egbw_back.sv
// ----------------------------------------------------------------------------
// egbw_back
// Packer: appends each operation's bits to the pending word, emits every
// filled word and the flush word through a two-entry output stage.
// ----------------------------------------------------------------------------
module egbw_back
    import egbw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    egbw_stream_if.sink   op_stream,
    egbw_stream_if.source out_stream
);

    // The pending bits are kept left-aligned with zeros below them.
    logic [WORD_BITS-1:0] p_word_reg;
    logic [WORD_BITS-1:0] p_word_next;
    logic [CNT_BITS-1:0]  p_cnt_reg;
    logic [CNT_BITS-1:0]  p_cnt_next;

    out_item_t slot0_reg;
    out_item_t slot0_next;
    out_item_t slot1_reg;
    out_item_t slot1_next;
    logic [1:0] out_cnt_reg;
    logic [1:0] out_cnt_next;

    op_t        e;
    logic [6:0] shamt;
    logic [6:0] fill_cnt;
    logic [95:0] combined;
    logic [1:0] nfull;
    logic [1:0] nres;
    out_item_t  r0;
    out_item_t  r1;
    logic       deq;
    logic       out_free;
    logic       pop;

    assign e = op_stream.data;

    always_comb
    begin
        shamt    = 7'd96 - 7'(p_cnt_reg) - 7'(e.nbits);
        fill_cnt = 7'(p_cnt_reg) + 7'(e.nbits);
        combined = {p_word_reg, 64'd0} | (96'(e.bits) << shamt);

        if (fill_cnt >= 7'd64)
        begin
            nfull = 2'd2;
        end
        else if (fill_cnt >= 7'd32)
        begin
            nfull = 2'd1;
        end
        else
        begin
            nfull = 2'd0;
        end
        nres = e.flush ? 2'd1 : nfull;

        r1.out_word   = combined[63:32];
        r1.valid_bits = 6'd32;
        r1.is_last    = 1'b0;
        r1.total_bits = e.total;
        if (e.flush)
        begin
            r0.out_word   = p_word_reg;
            r0.valid_bits = 6'(p_cnt_reg);
            r0.is_last    = 1'b1;
            r0.total_bits = e.total;
        end
        else
        begin
            r0.out_word   = combined[95:64];
            r0.valid_bits = 6'd32;
            r0.is_last    = 1'b0;
            r0.total_bits = e.total;
        end

        if (e.flush)
        begin
            p_word_next = '0;
            p_cnt_next  = '0;
        end
        else
        begin
            case (nfull)
                2'd0:
                begin
                    p_word_next = combined[95:64];
                    p_cnt_next  = CNT_BITS'(fill_cnt);
                end
                2'd1:
                begin
                    p_word_next = combined[63:32];
                    p_cnt_next  = CNT_BITS'(fill_cnt - 7'd32);
                end
                default:
                begin
                    p_word_next = combined[31:0];
                    p_cnt_next  = CNT_BITS'(fill_cnt - 7'd64);
                end
            endcase
        end
    end

    assign deq      = (out_cnt_reg != 2'd0) && out_stream.ready;
    assign out_free = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && out_stream.ready);

    // An operation that completes no word never waits for the output stage.
    assign op_stream.ready = (nres == 2'd0) || out_free;
    assign pop = op_stream.valid && op_stream.ready;

    always_comb
    begin
        slot0_next   = slot0_reg;
        slot1_next   = slot1_reg;
        out_cnt_next = out_cnt_reg - 2'(deq);
        if (pop && (nres != 2'd0))
        begin
            slot0_next   = r0;
            slot1_next   = r1;
            out_cnt_next = nres;
        end
        else if (deq && (out_cnt_reg == 2'd2))
        begin
            slot0_next = slot1_reg;
        end
    end

    assign out_stream.valid = (out_cnt_reg != 2'd0);
    assign out_stream.data  = slot0_reg;

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_word_reg  <= '0;
            p_cnt_reg   <= '0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
            if (pop)
            begin
                p_word_reg <= p_word_next;
                p_cnt_reg  <= p_cnt_next;
            end
        end
    end

endmodule

// File: rtl/expgolomb_bitstream_writer.sv
// ----------------------------------------------------------------------------
// expgolomb_bitstream_writer
// Packs raw bits and Exp-Golomb codes into 32-bit words, first bit at the top.
// ----------------------------------------------------------------------------
// Usage: syntax elements enter on in_stream (mode, value, length, fill_bit)
// and packed words leave on out_stream (out_word, valid_bits, is_last,
// total_bits). Both are valid/ready channels; a word moves when valid and
// ready are high at a rising edge of clk.
// The front classifies an element and keeps the bit total in the same cycle
// it accepts it; the element then waits in a queue of QUEUE_DEPTH entries.
// An accepted element is registered in the queue, and its words in the output stage.
// One element is accepted every cycle while the queue has room; an element
// that completes two words fills the output stage, and the packer stalls
// meanwhile only if it meets another element that completes a word.
// Elements that complete no word (and the unused modes, which are dropped)
// pass without touching the output.
// When out_stream stalls, up to two words are held in the output stage and
// the queue fills; in_stream drops ready only when the queue is full.
// Reset (rst_n low) empties the queue and clears the pending word, its bit
// count and the running bit total.
// ----------------------------------------------------------------------------
module expgolomb_bitstream_writer
    import egbw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    egbw_stream_if.sink   in_stream,
    egbw_stream_if.source out_stream
);

    egbw_stream_if #(.payload_t(op_t)) front_ch ();
    egbw_stream_if #(.payload_t(op_t)) back_ch ();

    egbw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .op_stream (front_ch)
    );

    egbw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .sink_ch   (front_ch),
        .source_ch (back_ch)
    );

    egbw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_stream  (back_ch),
        .out_stream (out_stream)
    );

    // Filled words always carry a full word of valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_stream.valid && !out_stream.data.is_last |-> out_stream.data.valid_bits == 6'd32)
    else $error("filled word without a full bit count");

    // A flush word is partial and zero below its valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_stream.valid && out_stream.data.is_last |->
            (out_stream.data.valid_bits < 6'd32) &&
            ((out_stream.data.out_word << out_stream.data.valid_bits) == 32'd0))
    else $error("flush word not left-aligned");

    // Unused modes never reach the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stream.valid && (in_stream.data.mode > MODE_FLUSH) |-> !front_ch.valid)
    else $error("unused mode queued");

    // A flush is a zero-length operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_ch.valid && back_ch.data.flush |-> back_ch.data.nbits == 6'd0)
    else $error("flush carries stream bits");

endmodule
